/* rtl/core/ymps_pkg.sv */
// Package: types, codes and helpers for the YMODEM packet sender.
package ymps_pkg;

   localparam int MaxBlock  = 1024;
   localparam int SmallBlk  = 128;
   localparam int AddrW     = $clog2(MaxBlock);
   localparam int CountW    = AddrW + 1;
   localparam int IdxW      = 11;

   localparam logic [7:0] B_SOH = 8'h01;
   localparam logic [7:0] B_STX = 8'h02;
   localparam logic [7:0] B_EOT = 8'h04;
   localparam logic [7:0] B_ACK = 8'h06;
   localparam logic [7:0] B_NAK = 8'h15;
   localparam logic [7:0] B_CAN = 8'h18;
   localparam logic [7:0] B_CRC = 8'h43;

   localparam logic [1:0] FUNC_RX   = 2'd0;
   localparam logic [1:0] FUNC_DATA = 2'd1;
   localparam logic [1:0] FUNC_TICK = 2'd2;
   localparam logic [1:0] FUNC_TMO  = 2'd3;

   localparam logic [1:0] CSR_SIZE  = 2'd0;
   localparam logic [1:0] CSR_RETRY = 2'd1;
   localparam logic [1:0] CSR_EOT   = 2'd2;

   localparam logic [2:0] ST_BUSY  = 3'd0;
   localparam logic [2:0] ST_LOAD  = 3'd1;
   localparam logic [2:0] ST_SEND  = 3'd2;
   localparam logic [2:0] ST_WAIT  = 3'd3;
   localparam logic [2:0] ST_DONE  = 3'd4;
   localparam logic [2:0] ST_FAIL  = 3'd5;

   typedef enum logic [3:0] {
      PH_MODE, PH_LOAD, PH_SEND, PH_REPLY, PH_EOT_SEND, PH_EOT_WAIT, PH_DONE, PH_FAIL
   } phase_type;

   typedef struct packed {
      logic [1:0] func;
      logic [7:0] rx_byte;
      logic [7:0] data_byte;
      logic       data_last;
      logic       file_end;
   } req_type;

   typedef struct packed {
      logic       tx_valid;
      logic [7:0] tx_byte;
      logic       tx_frame_end;
      logic [2:0] status;
      logic [7:0] packet_number;
   } rsp_type;

   // CRC-16 XMODEM, one byte
   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int i = 0; i < 8; i++) begin
         c = c[15] ? ({c[14:0], 1'b0} ^ 16'h1021) : {c[14:0], 1'b0};
      end
      return c;
   endfunction

endpackage

/* rtl/core/ymps_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read.
module ymps_ram #(
   parameter int Width = 8,
   parameter int Depth = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem_ff [Depth];

   // write, then register the read word
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule

/* rtl/core/ymodem_packet_sender_unit.sv */
// Top level of the YMODEM packet sender: frame control, buffer and checks.
//
//  channel | direction | handshake         | word
//  req     | in        | req_valid/ready   | req_type (func, bytes, flags)
//  rsp     | out       | rsp_valid/ready   | rsp_type (tx byte, status, number)
//  csr     | in        | csr_write         | size, retry limit, EOT limit
//
// One word a cycle is taken and answered while rsp drains; the frame byte is read
// from the buffer RAM as the tick before it is taken, so ticks may come every cycle.
// Buffer entries at or past the load count read as zero, so the buffer needs no
// clearing; request words are taken from the first cycle after reset.
// A one-word output register decouples rsp; req stalls only while it is full and
// not being drained.
module ymodem_packet_sender_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  ymps_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output ymps_pkg::rsp_type rsp_data,
   input  logic              csr_write,
   input  logic [1:0]        csr_index,
   input  logic [7:0]        csr_wdata
);
   import ymps_pkg::*;

   // configuration
   logic       size_ff;
   logic [7:0] retry_lim_ff;
   logic [3:0] eot_lim_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff      <= 1'b1;
         retry_lim_ff <= 8'd10;
         eot_lim_ff   <= 4'd5;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_SIZE:  size_ff      <= csr_wdata[0];
            CSR_RETRY: retry_lim_ff <= csr_wdata;
            CSR_EOT:   eot_lim_ff   <= csr_wdata[3:0];
            default: ;
         endcase
      end
   end

   // state
   phase_type        phase_ff, phase_in;
   logic [CountW-1:0] load_ff, load_in;
   logic [IdxW-1:0]  idx_ff, idx_in;
   logic [15:0]      crc_ff, crc_in;
   logic [7:0]       sum_ff, sum_in;
   logic [7:0]       seq_ff, seq_in;
   logic [7:0]       retry_ff, retry_in;
   logic             use_crc_ff, use_crc_in;
   logic             file_done_ff, file_done_in;
   logic             final_ff, final_in;
   logic [3:0]       eot_ff, eot_in;
   logic             can_ff, can_in;

   logic       out_full_ff;
   rsp_type    out_ff, out_in;

   logic [CountW-1:0] size_len;
   assign size_len = size_ff ? CountW'(MaxBlock) : CountW'(SmallBlk);

   logic accept;
   assign req_ready = !out_full_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   // RAM ports
   logic             wr_en;
   logic [AddrW-1:0] wr_addr, rd_addr;
   logic [7:0]       wr_data, rd_data;

   ymps_ram #(.Width(8), .Depth(MaxBlock)) u_buf (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
      .rd_addr(rd_addr), .rd_data(rd_data)
   );

   logic            is_rx;
   logic [7:0]      r;
   logic [IdxW-1:0] dofs;
   assign is_rx = (req_data.func == FUNC_RX && req_data.rx_byte != 8'h00)
                  || req_data.func == FUNC_TMO;
   assign r     = (req_data.func == FUNC_TMO) ? 8'h00 : req_data.rx_byte;
   assign dofs  = idx_ff - IdxW'(3);

   // read the payload byte that the next tick needs
   always_comb begin
      if (phase_ff == PH_SEND && accept && req_data.func == FUNC_TICK) begin
         rd_addr = AddrW'(idx_ff - IdxW'(2));
      end else begin
         rd_addr = AddrW'(dofs);
      end
   end

   // next state and result word
   always_comb begin
      logic            tv, fe, fin;
      logic [7:0]      tb;
      logic            retry_req;
      phase_in     = phase_ff;
      load_in      = load_ff;
      idx_in       = idx_ff;
      crc_in       = crc_ff;
      sum_in       = sum_ff;
      seq_in       = seq_ff;
      retry_in     = retry_ff;
      use_crc_in   = use_crc_ff;
      file_done_in = file_done_ff;
      final_in     = final_ff;
      eot_in       = eot_ff;
      can_in       = can_ff;
      wr_en        = 1'b0;
      wr_addr      = AddrW'(load_ff);
      wr_data      = req_data.data_byte;
      tv = 1'b0; fe = 1'b0; tb = 8'h00; fin = 1'b0; retry_req = 1'b0;

      if (accept) begin
         unique case (phase_ff)
            PH_MODE: if (is_rx) begin
               if (r == B_CRC || r == B_NAK) begin
                  use_crc_in = (r == B_CRC);
                  seq_in     = 8'd0;
                  retry_in   = 8'd0;
                  load_in    = '0;
                  if (final_ff) begin
                     idx_in = '0; crc_in = '0; sum_in = '0;
                     phase_in = PH_SEND;
                  end else begin
                     phase_in = PH_LOAD;
                  end
               end else begin
                  phase_in = PH_FAIL;
               end
            end
            PH_LOAD: if (req_data.func == FUNC_DATA) begin
               fin = req_data.data_last;
               if (load_ff < size_len) begin
                  wr_en   = 1'b1;
                  load_in = load_ff + CountW'(1);
                  if (load_in >= size_len) fin = 1'b1;
               end else begin
                  fin = 1'b1;
               end
               if (fin) begin
                  file_done_in = req_data.data_last && req_data.file_end;
                  idx_in = '0; crc_in = '0; sum_in = '0;
                  phase_in = PH_SEND;
               end
            end
            PH_SEND: if (req_data.func == FUNC_TICK) begin
               tv = 1'b1;
               if (idx_ff == IdxW'(0)) begin
                  tb = size_ff ? B_STX : B_SOH;
               end else if (idx_ff == IdxW'(1)) begin
                  tb = seq_ff;
               end else if (idx_ff == IdxW'(2)) begin
                  tb = ~seq_ff;
               end else if (dofs < IdxW'(size_len)) begin
                  // entries past the load count are the zero fill
                  tb     = (dofs < load_ff) ? rd_data : 8'h00;
                  crc_in = crc_byte(crc_ff, tb);
                  sum_in = sum_ff + tb;
               end else if (use_crc_ff && dofs == IdxW'(size_len)) begin
                  tb = crc_ff[15:8];
               end else begin
                  tb = use_crc_ff ? crc_ff[7:0] : sum_ff;
                  fe = 1'b1;
               end
               if (fe) begin
                  phase_in = PH_REPLY;
                  can_in   = 1'b0;
               end else begin
                  idx_in = idx_ff + IdxW'(1);
               end
            end
            PH_REPLY: if (is_rx) begin
               if (can_ff) begin
                  can_in = 1'b0;
                  if (r == B_CAN) phase_in = PH_FAIL;
                  else retry_req = 1'b1;
               end else if (r == B_ACK) begin
                  if (final_ff) begin
                     phase_in = PH_DONE;
                  end else if (file_done_ff) begin
                     eot_in   = 4'd0;
                     phase_in = PH_EOT_SEND;
                  end else begin
                     seq_in   = seq_ff + 8'd1;
                     load_in  = '0;
                     retry_in = 8'd0;
                     phase_in = PH_LOAD;
                  end
               end else if (r == B_CAN) begin
                  can_in = 1'b1;
               end else begin
                  retry_req = 1'b1;
               end
               if (retry_req) begin
                  if (retry_ff >= retry_lim_ff) begin
                     phase_in = PH_FAIL;
                  end else begin
                     retry_in = retry_ff + 8'd1;
                     idx_in = '0; crc_in = '0; sum_in = '0;
                     phase_in = PH_SEND;
                  end
               end
            end
            PH_EOT_SEND: if (req_data.func == FUNC_TICK) begin
               tv = 1'b1; tb = B_EOT; fe = 1'b1;
               if (eot_ff != 4'd15) eot_in = eot_ff + 4'd1;
               phase_in = PH_EOT_WAIT;
            end
            PH_EOT_WAIT: if (is_rx) begin
               if (r == B_ACK) begin
                  final_in = 1'b1;
                  phase_in = PH_MODE;
               end else if (eot_ff >= eot_lim_ff) begin
                  phase_in = PH_FAIL;
               end else begin
                  phase_in = PH_EOT_SEND;
               end
            end
            default: ;
         endcase
      end

      out_in.tx_valid      = tv;
      out_in.tx_byte       = tb;
      out_in.tx_frame_end  = fe;
      out_in.packet_number = seq_in;
      unique case (phase_in)
         PH_LOAD:                 out_in.status = ST_LOAD;
         PH_SEND, PH_EOT_SEND:    out_in.status = ST_SEND;
         PH_REPLY, PH_EOT_WAIT:   out_in.status = ST_WAIT;
         PH_DONE:                 out_in.status = ST_DONE;
         PH_FAIL:                 out_in.status = ST_FAIL;
         default:                 out_in.status = ST_BUSY;
      endcase
   end

   // hold state, advance on accepted words
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_MODE;
         load_ff      <= '0;
         idx_ff       <= '0;
         crc_ff       <= '0;
         sum_ff       <= '0;
         seq_ff       <= '0;
         retry_ff     <= '0;
         use_crc_ff   <= 1'b0;
         file_done_ff <= 1'b0;
         final_ff     <= 1'b0;
         eot_ff       <= '0;
         can_ff       <= 1'b0;
         out_full_ff  <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         load_ff      <= load_in;
         idx_ff       <= idx_in;
         crc_ff       <= crc_in;
         sum_ff       <= sum_in;
         seq_ff       <= seq_in;
         retry_ff     <= retry_in;
         use_crc_ff   <= use_crc_in;
         file_done_ff <= file_done_in;
         final_ff     <= final_in;
         eot_ff       <= eot_in;
         can_ff       <= can_in;
         if (accept)         out_full_ff <= 1'b1;
         else if (rsp_ready) out_full_ff <= 1'b0;
      end
   end

   // output word register
   always_ff @(posedge clock) begin
      if (accept) out_ff <= out_in;
   end

   assign rsp_valid = out_full_ff;
   assign rsp_data  = out_ff;
endmodule
